// File: hdl/sedd_pkg.sv
// Shared types, register indexes and an arithmetic helper for the serpentine dither.
package sedd_pkg;

  localparam int NCH = 3;
  localparam int EW  = 13;
  localparam int CEW = 12;
  localparam int ERW = 10;

  localparam logic [2:0] REG_ROW_WIDTH     = 3'd0;
  localparam logic [2:0] REG_RED_MAX       = 3'd1;
  localparam logic [2:0] REG_GREEN_MAX     = 3'd2;
  localparam logic [2:0] REG_BLUE_MAX      = 3'd3;
  localparam logic [2:0] REG_RED_SHIFT     = 3'd4;
  localparam logic [2:0] REG_GREEN_SHIFT   = 3'd5;
  localparam logic [2:0] REG_BLUE_SHIFT    = 3'd6;
  localparam logic [2:0] REG_FIRST_ROW_ODD = 3'd7;

  localparam logic [1:0] TGT_SAME   = 2'd0;
  localparam logic [1:0] TGT_LOWER  = 2'd1;
  localparam logic [1:0] TGT_HIGHER = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_SETUP, ST_RDCUR, ST_SUM, ST_MUL,
    ST_QUANT, ST_DIVINIT, ST_DIV, ST_ERR, ST_NRD, ST_NWR, ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic setup;
    logic rdcur;
    logic sum;
    logic mul;
    logic quant;
    logic div_init;
    logic div_step;
    logic err;
    logic nrd;
    logic nwr;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic tgt_last;
    logic out_free;
  } sts_t;

  // Floor of d/255: a close estimate that falls short by at most two, then corrected.
  function automatic logic [9:0] div255(input logic [17:0] d);
    logic [19:0] est;
    logic [19:0] r;
    logic [19:0] q;
    est = (20'(d) + 20'(d >> 8)) >> 8;
    r   = 20'(d) - ((est << 8) - est);
    if (r >= 20'd510) begin
      q = est + 20'd2;
    end else if (r >= 20'd255) begin
      q = est + 20'd1;
    end else begin
      q = est;
    end
    return q[9:0];
  endfunction

endpackage

// File: hdl/sedd_ram.sv
// Generic one-write, one-read memory with registered read data.
module sedd_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sedd_ctrl.sv
// Sequencer for the per-pixel steps of the serpentine dither.
module sedd_ctrl
  import sedd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_frame_start,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:    if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = in_frame_start ? ST_CLEAR : ST_SETUP;
      ST_CLEAR:   if (sts.clr_last) state_nxt = ST_SETUP;
      ST_SETUP:   state_nxt = ST_RDCUR;
      ST_RDCUR:   state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_QUANT;
      ST_QUANT:   state_nxt = ST_DIVINIT;
      ST_DIVINIT: state_nxt = ST_DIV;
      ST_DIV:     if (sts.div_last) state_nxt = ST_ERR;
      ST_ERR:     state_nxt = ST_NRD;
      ST_NRD:     state_nxt = ST_NWR;
      ST_NWR:     state_nxt = sts.tgt_last ? ST_DONE : ST_NRD;
      ST_DONE:    if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT:    cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_CLEAR:   cmd.clr = 1'b1;
      ST_SETUP:   cmd.setup = 1'b1;
      ST_RDCUR:   cmd.rdcur = 1'b1;
      ST_SUM:     cmd.sum = 1'b1;
      ST_MUL:     cmd.mul = 1'b1;
      ST_QUANT:   cmd.quant = 1'b1;
      ST_DIVINIT: cmd.div_init = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_ERR:     cmd.err = 1'b1;
      ST_NRD:     cmd.nrd = 1'b1;
      ST_NWR:     cmd.nwr = 1'b1;
      ST_DONE:    cmd.done = sts.out_free;
      default:    cmd = '0;
    endcase
  end

  a_plain_pixel_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && !in_frame_start) |=> state_r == ST_SETUP)
    else $error("pixel without frame start did not go to setup");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> sts.out_free)
    else $error("result loaded while output slot busy");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !sts.div_last) |=> state_r == ST_DIV)
    else $error("divider left before its last step");

endmodule

// File: hdl/sedd_dp.sv
// Datapath of the serpentine dither: settings, line stores, quantizer and output register.
module sedd_dp
  import sedd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_start,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] out_pixel_value,
  output logic [9:0]  out_column,
  output logic        out_row_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int XW = (AW > 10) ? AW : 10;
  localparam int MW = NCH * EW;
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

  logic [10:0] row_width_r;
  logic [9:0]  max_r [NCH];
  logic [4:0]  shift_r [NCH];
  logic        fro_r;

  logic [7:0]  pix_r [NCH];
  logic        fs_r;

  logic [AW-1:0] col_r;
  logic          par_r;
  logic          bank_r;
  logic [AW-1:0] x_r;
  logic          last_r;
  logic signed [CEW-1:0] carried_r [NCH];

  logic [AW-1:0] clr_r;
  logic [1:0]    k_r;
  logic [2:0]    dcnt_r;

  logic [7:0]  uc_r [NCH];
  logic [17:0] prod_r [NCH];
  logic [9:0]  field_r [NCH];
  logic [9:0]  q_r [NCH];
  logic [17:0] rem_r [NCH];
  logic [7:0]  quo_r [NCH];
  logic signed [ERW-1:0] e_r [NCH];

  logic        out_valid_r;
  logic [31:0] out_pix_r;
  logic [9:0]  out_col_r;
  logic        out_end_r;

  logic [CW-1:0] w_c;
  logic [9:0]    meff [NCH];
  logic [AW-1:0] col0;
  logic [AW-1:0] col1;
  logic          par0;
  logic          bank0;
  logic          rowstart;
  logic [AW-1:0] x_c;
  logic          last_c;

  logic [AW-1:0] tgt_addr;
  logic          tgt_ok;
  logic [2:0]    weight;

  logic          we_a;
  logic          we_b;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [MW-1:0] wdata;
  logic [MW-1:0] rd_a;
  logic [MW-1:0] rd_b;
  logic [MW-1:0] cur_rd;
  logic [MW-1:0] nxt_rd;
  logic [MW-1:0] new_word;

  logic [7:0]  uc_c [NCH];
  logic [18:0] trial [NCH];
  logic [41:0] shifted [NCH];
  logic [31:0] word_c;
  logic [XW-1:0] x_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= 11'd1024;
      max_r[0]    <= 10'd255;
      max_r[1]    <= 10'd255;
      max_r[2]    <= 10'd255;
      shift_r[0]  <= 5'd16;
      shift_r[1]  <= 5'd8;
      shift_r[2]  <= 5'd0;
      fro_r       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:     row_width_r <= cfg_data;
        REG_RED_MAX:       max_r[0] <= cfg_data[9:0];
        REG_GREEN_MAX:     max_r[1] <= cfg_data[9:0];
        REG_BLUE_MAX:      max_r[2] <= cfg_data[9:0];
        REG_RED_SHIFT:     shift_r[0] <= cfg_data[4:0];
        REG_GREEN_SHIFT:   shift_r[1] <= cfg_data[4:0];
        REG_BLUE_SHIFT:    shift_r[2] <= cfg_data[4:0];
        REG_FIRST_ROW_ODD: fro_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CW'(row_width_r) == '0) begin
      w_c = CW'(1);
    end else if (CW'(row_width_r) > MAXW) begin
      w_c = MAXW;
    end else begin
      w_c = CW'(row_width_r);
    end
    for (int ch = 0; ch < NCH; ch++) begin
      meff[ch] = (max_r[ch] == '0) ? 10'd1 : max_r[ch];
    end
  end

  always_comb begin
    col0  = fs_r ? '0 : col_r;
    par0  = fs_r ? fro_r : par_r;
    bank0 = fs_r ? 1'b0 : bank_r;
    if (CW'(col0) >= w_c) begin
      col1 = AW'(w_c - CW'(1));
    end else begin
      col1 = col0;
    end
    rowstart = (col1 == '0);
    x_c      = par0 ? col1 : AW'(w_c - CW'(1) - CW'(col1));
    last_c   = (CW'(col1) == w_c - CW'(1));
  end

  always_comb begin
    case (k_r)
      TGT_SAME: begin
        tgt_addr = x_r;
        tgt_ok   = 1'b1;
        weight   = 3'd5;
      end
      TGT_LOWER: begin
        tgt_addr = x_r - AW'(1);
        tgt_ok   = (x_r != '0);
        weight   = par_r ? 3'd3 : 3'd1;
      end
      default: begin
        tgt_addr = x_r + AW'(1);
        tgt_ok   = (CW'(x_r) + CW'(1) < w_c);
        weight   = par_r ? 3'd1 : 3'd3;
      end
    endcase
  end

  assign cur_rd = bank_r ? rd_b : rd_a;
  assign nxt_rd = bank_r ? rd_a : rd_b;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      logic signed [13:0] sumv;
      logic signed [15:0] cv;
      logic signed [13:0] wprod;
      sumv = 14'(signed'(cur_rd[ch*EW +: EW])) + 14'(carried_r[ch]);
      cv   = 16'(signed'({1'b0, pix_r[ch]})) + 16'(sumv >>> 4);
      if (cv < 0) begin
        uc_c[ch] = 8'd0;
      end else if (cv > 16'sd255) begin
        uc_c[ch] = 8'd255;
      end else begin
        uc_c[ch] = cv[7:0];
      end
      trial[ch] = {1'b0, rem_r[ch]} - (19'(meff[ch]) << dcnt_r);
      wprod = signed'({1'b0, weight}) * e_r[ch];
      new_word[ch*EW +: EW] = nxt_rd[ch*EW +: EW] + EW'(wprod);
      shifted[ch] = 42'(field_r[ch]) << shift_r[ch];
    end
    word_c = shifted[0][31:0] + shifted[1][31:0] + shifted[2][31:0];
    x_ext  = XW'(x_r);
  end

  assign we_a  = cmd.clr | (cmd.sum & ~bank_r) | (cmd.nwr & tgt_ok & bank_r);
  assign we_b  = cmd.clr | (cmd.sum & bank_r) | (cmd.nwr & tgt_ok & ~bank_r);
  assign waddr = cmd.clr ? clr_r : (cmd.sum ? x_r : tgt_addr);
  assign raddr = cmd.rdcur ? x_r : tgt_addr;
  assign wdata = (cmd.clr | cmd.sum) ? '0 : new_word;

  sedd_ram #(.WIDTH(MW), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_a)
  );

  sedd_ram #(.WIDTH(MW), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      par_r  <= 1'b0;
      bank_r <= 1'b0;
      clr_r  <= '0;
      k_r    <= TGT_SAME;
      dcnt_r <= '0;
      for (int ch = 0; ch < NCH; ch++) begin
        carried_r[ch] <= '0;
      end
    end else begin
      if (cmd.clr) begin
        clr_r <= sts.clr_last ? '0 : clr_r + AW'(1);
      end
      if (cmd.setup) begin
        col_r  <= col1;
        par_r  <= par0;
        bank_r <= bank0 ^ rowstart;
        if (rowstart) begin
          for (int ch = 0; ch < NCH; ch++) begin
            carried_r[ch] <= '0;
          end
        end
      end
      if (cmd.div_init) begin
        dcnt_r <= 3'd7;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 3'd1;
      end
      if (cmd.err) begin
        k_r <= TGT_SAME;
      end else if (cmd.nwr) begin
        k_r <= k_r + 2'd1;
      end
      if (cmd.done) begin
        col_r <= last_r ? '0 : col_r + AW'(1);
        par_r <= par_r ^ last_r;
        for (int ch = 0; ch < NCH; ch++) begin
          carried_r[ch] <= CEW'(e_r[ch]) * CEW'(7);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_r[0] <= in_red;
      pix_r[1] <= in_green;
      pix_r[2] <= in_blue;
      fs_r     <= in_frame_start;
    end
    if (cmd.setup) begin
      x_r    <= x_c;
      last_r <= last_c;
    end
    for (int ch = 0; ch < NCH; ch++) begin
      if (cmd.sum) begin
        uc_r[ch] <= uc_c[ch];
      end
      if (cmd.mul) begin
        prod_r[ch] <= 18'(uc_r[ch]) * 18'(meff[ch]);
      end
      if (cmd.quant) begin
        field_r[ch] <= div255(prod_r[ch]);
        q_r[ch]     <= div255(prod_r[ch] + 18'd127);
      end
      if (cmd.div_init) begin
        rem_r[ch] <= (18'(q_r[ch]) << 8) - 18'(q_r[ch]);
        quo_r[ch] <= '0;
      end else if (cmd.div_step) begin
        if (!trial[ch][18]) begin
          rem_r[ch] <= trial[ch][17:0];
        end
        quo_r[ch] <= {quo_r[ch][6:0], ~trial[ch][18]};
      end
      if (cmd.err) begin
        e_r[ch] <= signed'({2'b00, uc_r[ch]}) - signed'({2'b00, quo_r[ch]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_pix_r <= word_c;
      out_col_r <= x_ext[9:0];
      out_end_r <= last_r;
    end
  end

  assign sts.clr_last = (clr_r == AW'(MAX_WIDTH - 1));
  assign sts.div_last = (dcnt_r == '0);
  assign sts.tgt_last = (k_r == TGT_HIGHER);
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;
  assign out_column      = out_col_r;
  assign out_row_end     = out_end_r;

endmodule

// File: hdl/serpentine_error_diffusion_dither.sv
// Top level of the serpentine error-diffusion dither to a packed truecolor word.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_red, in_green, in_blue, in_frame_start
//   out       out_valid / out_ready  out_pixel_value, out_column, out_row_end
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each pixel runs an eight-step restoring divider for the rounded level and three
// read-modify-writes of the next-row line store before the next pixel is accepted.
// After reset, and on each beat that carries a frame start, both line stores are cleared
// one entry per cycle across all MAX_WIDTH entries; no pixel is taken meanwhile.
// A finished result sits in the output register while the next pixel is taken in; work
// stalls at the end of a pixel only if that register is still full and out_ready is low.
module serpentine_error_diffusion_dither
  import sedd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_value,
  output logic [9:0]  out_column,
  output logic        out_row_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sedd_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_frame_start(in_frame_start),
    .in_ready(in_ready),
    .sts(sts),
    .cmd(cmd)
  );

  sedd_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_frame_start(in_frame_start),
    .cfg_valid(cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_pixel_value(out_pixel_value),
    .out_column(out_column),
    .out_row_end(out_row_end)
  );

endmodule

// File: verif/tb_serpentine_error_diffusion_dither.sv
// Testbench for the serpentine error-diffusion dither, with a scoreboard that predicts each pixel.
module tb_serpentine_error_diffusion_dither;
  import sedd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 1024;
  localparam int IDLE_LIMIT = 6000;
  localparam int ITEM_GOAL  = 1200;

  typedef struct {
    logic [31:0] pixel;
    logic [9:0]  column;
    logic        row_end;
  } dither_result_t;

  class dither_scoreboard;
    int unsigned row_width, red_max, green_max, blue_max;
    int unsigned red_shift, green_shift, blue_shift, first_row_odd;
    int          err_line[2][LINE_DEPTH][3];
    int          carry[3];
    int unsigned bank, col_count, parity;
    dither_result_t pending_px[$];
    int          errors;
    int          checked;

    function void reset_state();
      row_width = 1024; red_max = 255; green_max = 255; blue_max = 255;
      red_shift = 16; green_shift = 8; blue_shift = 0; first_row_odd = 0;
      foreach (err_line[b, x, c]) err_line[b][x][c] = 0;
      foreach (carry[c]) carry[c] = 0;
      bank = 0; col_count = 0; parity = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [10:0] data);
      case (idx)
        REG_ROW_WIDTH:     row_width = data;
        REG_RED_MAX:       red_max = data[9:0];
        REG_GREEN_MAX:     green_max = data[9:0];
        REG_BLUE_MAX:      blue_max = data[9:0];
        REG_RED_SHIFT:     red_shift = data[4:0];
        REG_GREEN_SHIFT:   green_shift = data[4:0];
        REG_BLUE_SHIFT:    blue_shift = data[4:0];
        REG_FIRST_ROW_ODD: first_row_odd = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      int unsigned w, x, cb, nb, uc, field, q, m;
      int unsigned lvl[3], sh[3];
      int          chan_in[3];
      int          c, e;
      logic [63:0] word;
      logic        ltr, last;
      dither_result_t res;
      w = (row_width == 0) ? 1 : (row_width > LINE_DEPTH ? LINE_DEPTH : row_width);
      lvl[0] = red_max ? red_max : 1;
      lvl[1] = green_max ? green_max : 1;
      lvl[2] = blue_max ? blue_max : 1;
      sh[0] = red_shift; sh[1] = green_shift; sh[2] = blue_shift;
      chan_in[0] = r; chan_in[1] = g; chan_in[2] = b;
      if (fs) begin
        foreach (err_line[i, j, k]) err_line[i][j][k] = 0;
        foreach (carry[k]) carry[k] = 0;
        col_count = 0; bank = 0; parity = first_row_odd;
      end
      if (col_count >= w) col_count = w - 1;
      if (col_count == 0) begin
        bank ^= 1;
        foreach (carry[k]) carry[k] = 0;
      end
      cb = bank; nb = bank ^ 1;
      ltr = parity[0];
      x = ltr ? col_count : (w - 1 - col_count);
      word = '0;
      for (int ch = 0; ch < 3; ch++) begin
        m = lvl[ch];
        c = chan_in[ch] + ((err_line[cb][x][ch] + carry[ch]) >>> 4);
        if (c < 0) c = 0;
        else if (c > 255) c = 255;
        err_line[cb][x][ch] = 0;
        uc = c;
        field = uc * m / 255;
        word += 64'(field) << sh[ch];
        q = (2 * uc * m + 255) / 510;
        e = c - int'(q * 255 / m);
        err_line[nb][x][ch] += 5 * e;
        if (ltr) begin
          if (x > 0) err_line[nb][x - 1][ch] += 3 * e;
          if (x + 1 < w) err_line[nb][x + 1][ch] += e;
        end else begin
          if (x + 1 < w) err_line[nb][x + 1][ch] += 3 * e;
          if (x > 0) err_line[nb][x - 1][ch] += e;
        end
        carry[ch] = 7 * e;
      end
      last = (col_count == w - 1);
      if (last) begin
        col_count = 0;
        parity ^= 1;
      end else begin
        col_count++;
      end
      res.pixel = word[31:0];
      res.column = x[9:0];
      res.row_end = last;
      pending_px.push_back(res);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)", what, got, want,
               checked);
    endfunction

    function void check_pixel(logic [31:0] pv, logic [9:0] col, logic re);
      dither_result_t exp_px;
      if (pending_px.size() == 0) begin
        report("unexpected beat", pv, 0);
        return;
      end
      exp_px = pending_px.pop_front();
      if (pv !== exp_px.pixel) report("pixel_value", pv, exp_px.pixel);
      if (col !== exp_px.column) report("column", col, exp_px.column);
      if (re !== exp_px.row_end) report("row_end", re, exp_px.row_end);
      checked++;
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_frame_start;
  logic [7:0]  in_red, in_green, in_blue;
  logic        out_valid, out_ready, out_row_end;
  logic [31:0] out_pixel_value;
  logic [9:0]  out_column;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;

  dither_scoreboard sb;
  bit calm;
  bit hold_request;
  int sent_px, frame_starts, reg_writes, idle_cycles;

  serpentine_error_diffusion_dither u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_value(out_pixel_value), .out_column(out_column), .out_row_end(out_row_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a beat", idle_cycles);
        $display("FAIL serpentine_error_diffusion_dither");
        $finish;
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_pixel(out_pixel_value, out_column, out_row_end);
      if (hold_request) begin
        out_ready <= 1'b0;
        hold_request = 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic set_config(int unsigned w, int unsigned rm, int unsigned gm, int unsigned bm,
                            int unsigned rs, int unsigned gs, int unsigned bs, bit odd);
    write_reg(REG_ROW_WIDTH, w);
    write_reg(REG_RED_MAX, rm);
    write_reg(REG_GREEN_MAX, gm);
    write_reg(REG_BLUE_MAX, bm);
    write_reg(REG_RED_SHIFT, rs);
    write_reg(REG_GREEN_SHIFT, gs);
    write_reg(REG_BLUE_SHIFT, bs);
    write_reg(REG_FIRST_ROW_ODD, odd);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 28) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(r, g, b, fs);
    sent_px++;
    if (fs) frame_starts++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic int unsigned pick_level();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 1023;
      3: return $urandom_range(0, 2047);
      default: return $urandom_range(1, 31);
    endcase
  endfunction

  function automatic int unsigned pick_width();
    if ($urandom_range(99) < 75) return $urandom_range(1, 24);
    case ($urandom_range(4))
      0: return 0;
      1: return 1024;
      2: return 2047;
      3: return $urandom_range(1025, 2046);
      default: return $urandom_range(25, 1023);
    endcase
  endfunction

  initial begin
    int phase, count;
    sb = new();
    sb.reset_state();
    rst_n <= 1'b0;
    in_valid <= 1'b0; in_red <= '0; in_green <= '0; in_blue <= '0; in_frame_start <= 1'b0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    calm = 1'b0; hold_request = 1'b0;
    sent_px = 0; frame_starts = 0; reg_writes = 0; idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd1, 8'd254, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    drain();

    set_config(0, 0, 0, 0, 31, 31, 0, 1'b1);
    send_pixel(8'd200, 8'd100, 8'd255, 1'b1);
    send_pixel(8'd7, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd128, 8'd64, 1'b0);
    drain();

    set_config(8, 1023, 1, 2, 0, 10, 20, 1'b0);
    send_pixel(8'd1, 8'd254, 8'd127, 1'b1);
    for (int i = 0; i < 6; i++) send_pixel($urandom, $urandom, $urandom, 1'b0);
    drain();

    // Narrowing the row without a frame start ends the current row early.
    set_config(3, 255, 1023, 7, 16, 8, 0, 1'b0);
    for (int i = 0; i < 5; i++) send_pixel($urandom, $urandom, $urandom, 1'b0);
    drain();

    set_config(2047, 31, 63, 31, 11, 5, 0, 1'b1);
    for (int i = 0; i < 5; i++) send_pixel($urandom, $urandom, $urandom, i == 0);
    drain();

    phase = 0;
    while (sent_px < ITEM_GOAL) begin
      calm = (phase >= 6 && phase <= 9);
      set_config(pick_width(), pick_level(), pick_level(), pick_level(),
                 $urandom_range(31), $urandom_range(31), $urandom_range(31), $urandom_range(1));
      count = $urandom_range(20, 80);
      if (phase == 3) begin
        hold_request = 1'b1;
        count = 100;
      end
      for (int i = 0; i < count; i++) begin
        send_pixel($urandom, $urandom, $urandom,
                   (i == 0 && $urandom_range(9) != 0) || $urandom_range(199) == 0);
      end
      drain();
      phase++;
    end
    calm = 1'b0;
    repeat (60) @(posedge clk);

    while (sb.pending_px.size() != 0) begin
      void'(sb.pending_px.pop_front());
      sb.report("missing beat", 0, 0);
    end
    $display("Ran %0d pixels over %0d random phases with %0d frame starts.",
             sent_px, phase, frame_starts);
    $display("Wrote %0d registers and checked %0d results.", reg_writes, sb.checked);
    if (sb.errors == 0) begin
      $display("PASS serpentine_error_diffusion_dither");
    end else begin
      $display("FAIL serpentine_error_diffusion_dither");
    end
    $finish;
  end

endmodule

// File: serpentine_error_diffusion_dither.f
hdl/sedd_pkg.sv
hdl/sedd_ram.sv
hdl/sedd_ctrl.sv
hdl/sedd_dp.sv
hdl/serpentine_error_diffusion_dither.sv
verif/tb_serpentine_error_diffusion_dither.sv
